// File: rtl/incremental_pid_controller_defines.svh
// ----------------------------------------------------------------------------
// Incremental PID controller - assertion macros
// Shared helpers for the concurrent checks of the controller.
// ----------------------------------------------------------------------------
`ifndef INCREMENTAL_PID_CONTROLLER_DEFINES_SVH
`define INCREMENTAL_PID_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define IPID_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IPID_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ipid_pkg.sv
// ----------------------------------------------------------------------------
// Incremental PID controller - package
// Widths, register indexes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package ipid_pkg;

  localparam int DATA_W    = 16;
  localparam int ERR_W     = 17;
  localparam int DIFF_W    = 19;
  localparam int PROD_W    = 35;
  localparam int ACC_W     = 37;
  localparam int FRAC_W    = 8;
  localparam int LIM_W     = 15;
  localparam int CFG_IDX_W = 3;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int QLVL_W    = 2;

  localparam logic signed [DATA_W-1:0] DRIVE_MAX_RST = 16'sd16384;
  localparam logic signed [DATA_W-1:0] DRIVE_MIN_RST = -16'sd16384;
  localparam logic [LIM_W-1:0]         I_LIMIT_RST   = 15'd200;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_DRIVE_MAX = 3'd3,
    REG_DRIVE_MIN = 3'd4,
    REG_I_LIMIT   = 3'd5
  } ipid_reg_t;

  typedef struct packed {
    logic                    clr;
    logic signed [ERR_W-1:0] err;
  } ipid_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] gain_p;
    logic signed [DATA_W-1:0] gain_i;
    logic signed [DATA_W-1:0] gain_d;
    logic signed [DATA_W-1:0] drive_max;
    logic signed [DATA_W-1:0] drive_min;
    logic [LIM_W-1:0]         i_limit;
  } ipid_cfg_t;

  typedef struct packed {
    logic busy;
    logic fin;
    logic hold;
  } ipid_status_t;

endpackage

`default_nettype wire

// File: rtl/ipid_if.sv
// ----------------------------------------------------------------------------
// Incremental PID controller - channel interfaces
// Sample channel (setpoint, measured, clear) and result channel (drive).
// ----------------------------------------------------------------------------
`default_nettype none

interface ipid_sample_if import ipid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] setpoint;
  logic signed [DATA_W-1:0] measured;
  logic                     clear;

  modport source (output valid, setpoint, measured, clear, input ready);
  modport sink   (input valid, setpoint, measured, clear, output ready);
endinterface

interface ipid_result_if import ipid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drive;

  modport source (output valid, drive, input ready);
  modport sink   (input valid, drive, output ready);
endinterface

`default_nettype wire

// File: rtl/incremental_pid_controller.sv
// ----------------------------------------------------------------------------
// Incremental PID controller - top level
// Velocity-form PID with Q8.8 gains, clamped I increment and saturated drive.
//
//   channel   dir   payload
//   sample    in    setpoint[16] s, measured[16] s, clear[1]
//   result    out   drive[16] s
//   cfg       in    cfg_write, cfg_index[3], cfg_data[16]
//
// Items pass the shared multiplier in the back end one after another
// (P, I and D products in turn; finishing overlaps the next item's P).
// Synchronous reset, no clearing pass; the front register and a two-entry
// queue keep taking items while a result waits at the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "incremental_pid_controller_defines.svh"

module incremental_pid_controller import ipid_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_data,
  ipid_sample_if.sink               sample,
  ipid_result_if.source             result
);

  ipid_cfg_t         cfg;
  ipid_status_t      st;
  logic              q_push;
  ipid_item_t        q_push_item;
  logic              q_push_ready;
  logic              q_pop;
  logic              q_pop_valid;
  ipid_item_t        q_pop_item;
  logic [QLVL_W-1:0] q_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p    <= '0;
      cfg.gain_i    <= '0;
      cfg.gain_d    <= '0;
      cfg.drive_max <= DRIVE_MAX_RST;
      cfg.drive_min <= DRIVE_MIN_RST;
      cfg.i_limit   <= I_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GAIN_P:    cfg.gain_p    <= cfg_data;
        REG_GAIN_I:    cfg.gain_i    <= cfg_data;
        REG_GAIN_D:    cfg.gain_d    <= cfg_data;
        REG_DRIVE_MAX: cfg.drive_max <= cfg_data;
        REG_DRIVE_MIN: cfg.drive_min <= cfg_data;
        REG_I_LIMIT:   cfg.i_limit   <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  ipid_front u_front (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .push       (q_push),
    .push_item  (q_push_item),
    .push_ready (q_push_ready)
  );

  ipid_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_push_item),
    .push_ready (q_push_ready),
    .pop        (q_pop),
    .pop_valid  (q_pop_valid),
    .pop_item   (q_pop_item),
    .level      (q_level)
  );

  ipid_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (q_pop_valid),
    .pop_item  (q_pop_item),
    .pop       (q_pop),
    .result    (result),
    .st        (st)
  );

  `IPID_CHECK_NOW(a_fin_when_idle, st.fin, !st.busy, "finish overlaps a busy phase")
  `IPID_CHECK_NOW(a_no_overfill, q_push && !q_push_ready, q_level == QLVL_W'(QDEPTH), "queue overfill")
  `IPID_CHECK_NEXT(a_fin_to_result, st.fin && !st.hold, result.valid, "finished item lost")

endmodule

`default_nettype wire

// File: rtl/ipid_front.sv
// ----------------------------------------------------------------------------
// Incremental PID controller - front end
// Takes sample items, forms the error and registers it for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ipid_front import ipid_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  ipid_sample_if.sink     sample,
  output      logic       push,
  output      ipid_item_t push_item,
  input  wire logic       push_ready
);

  logic                    f_valid;
  ipid_item_t              f_item;
  logic signed [ERR_W-1:0] err;

  assign err          = ERR_W'(sample.setpoint) - ERR_W'(sample.measured);
  assign sample.ready = !f_valid || push_ready;
  assign push         = f_valid;
  assign push_item    = f_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (sample.ready) begin
      f_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      f_item.clr <= sample.clear;
      f_item.err <= sample.clear ? '0 : err;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ipid_queue.sv
// ----------------------------------------------------------------------------
// Incremental PID controller - item queue
// Two-entry queue between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ipid_queue import ipid_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire ipid_item_t  push_item,
  output      logic        push_ready,
  input  wire logic        pop,
  output      logic        pop_valid,
  output      ipid_item_t  pop_item,
  output      logic [QLVL_W-1:0] level
);

  ipid_item_t        mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic              do_push;
  logic              do_pop;

  assign push_ready = level != QLVL_W'(QDEPTH);
  assign pop_valid  = level != '0;
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      level <= level + QLVL_W'(do_push) - QLVL_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ipid_back.sv
// ----------------------------------------------------------------------------
// Incremental PID controller - back end
// One shared multiplier forms the P, I and D increments in turn, then
// truncation, saturation and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ipid_back import ipid_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire ipid_cfg_t    cfg,
  input  wire logic         pop_valid,
  input  wire ipid_item_t   pop_item,
  output      logic         pop,
  ipid_result_if.source     result,
  output      ipid_status_t st
);

  typedef enum logic [1:0] {PH_IDLE, PH_I, PH_D, PH_SUM} phase_t;

  phase_t                   phase;
  logic                     fin;
  logic                     hold;
  logic                     out_valid;
  logic signed [DATA_W-1:0] drive_out;

  logic signed [ERR_W-1:0]  err_last;
  logic signed [ERR_W-1:0]  err_before;
  logic signed [DATA_W-1:0] held;

  logic signed [ERR_W-1:0]  e_r;
  logic signed [DIFF_W-1:0] dd_r;
  logic                     clr_r;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  logic signed [DIFF_W-1:0] dp;
  logic signed [DIFF_W-1:0] dd;
  logic signed [DATA_W-1:0] mul_a;
  logic signed [DIFF_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [PROD_W-1:0] lim_pos;
  logic signed [PROD_W-1:0] lim_neg;
  logic signed [PROD_W-1:0] i_cl;
  logic signed [ACC_W-1:0]  acc_base;
  logic signed [ACC_W-1:0]  quot;
  logic signed [ACC_W-1:0]  quot_t;
  logic signed [DATA_W-1:0] drive_sat;

  assign hold = fin && out_valid && !result.ready;
  assign pop  = (phase == PH_IDLE) && pop_valid && !hold;

  assign result.valid = out_valid;
  assign result.drive = drive_out;

  assign st.busy = phase != PH_IDLE;
  assign st.fin  = fin;
  assign st.hold = hold;

  assign dp = DIFF_W'(pop_item.err) - DIFF_W'(err_last);
  assign dd = DIFF_W'(pop_item.err) - (DIFF_W'(err_last) <<< 1) + DIFF_W'(err_before);

  always_comb begin
    unique case (phase)
      PH_IDLE: begin
        mul_a = cfg.gain_p;
        mul_b = dp;
      end
      PH_I: begin
        mul_a = cfg.gain_i;
        mul_b = DIFF_W'(e_r);
      end
      PH_D: begin
        mul_a = cfg.gain_d;
        mul_b = dd_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_next = mul_a * mul_b;

  // I increment clamp, limit scaled to 1/256 units
  assign lim_pos = PROD_W'({1'b0, cfg.i_limit, {FRAC_W{1'b0}}});
  assign lim_neg = -lim_pos;

  always_comb begin
    priority if (prod > lim_pos) begin
      i_cl = lim_pos;
    end else if (prod < lim_neg) begin
      i_cl = lim_neg;
    end else begin
      i_cl = prod;
    end
  end

  assign acc_base = {{(ACC_W-DATA_W-FRAC_W){held[DATA_W-1]}}, held, {FRAC_W{1'b0}}};

  // truncate toward zero
  assign quot   = acc >>> FRAC_W;
  assign quot_t = quot + {{(ACC_W-1){1'b0}},
                          acc[ACC_W-1] && (acc[FRAC_W-1:0] != '0)};

  always_comb begin
    priority if (quot_t > ACC_W'(cfg.drive_max)) begin
      drive_sat = cfg.drive_max;
    end else if (quot_t < ACC_W'(cfg.drive_min)) begin
      drive_sat = cfg.drive_min;
    end else begin
      drive_sat = quot_t[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      fin        <= 1'b0;
      out_valid  <= 1'b0;
      err_last   <= '0;
      err_before <= '0;
      held       <= '0;
    end else begin
      if (out_valid && result.ready && !fin) out_valid <= 1'b0;
      if (!hold) begin
        fin <= (phase == PH_SUM);
        unique case (phase)
          PH_IDLE: if (pop) phase <= PH_I;
          PH_I:    phase <= PH_D;
          PH_D:    phase <= PH_SUM;
          PH_SUM:  phase <= PH_IDLE;
          default: phase <= PH_IDLE;
        endcase
        if (pop) begin
          err_last   <= pop_item.err;
          err_before <= pop_item.clr ? '0 : err_last;
        end
        if (fin) begin
          out_valid <= 1'b1;
          drive_out <= clr_r ? '0 : drive_sat;
          held      <= clr_r ? '0 : drive_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      prod <= prod_next;
      if (pop) begin
        e_r   <= pop_item.err;
        dd_r  <= dd;
        clr_r <= pop_item.clr;
      end
      unique case (phase)
        PH_I:    acc <= acc_base + ACC_W'(prod);
        PH_D:    acc <= acc + ACC_W'(i_cl);
        PH_SUM:  acc <= acc + ACC_W'(prod);
        default: acc <= acc;
      endcase
    end
  end

endmodule

`default_nettype wire
